// ----- rtl/midpoint_line_rasterizer_core_defines.svh -----
// assertion macros for the midpoint line rasterizer checker
// no dependencies; included by the checker file only
`ifndef MIDPOINT_LINE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlr check failed");

// consequent checked in the cycle after the antecedent
`define MLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlr check failed");

`endif

// ----- rtl/mlr_pkg.sv -----
// shared types and constants of the midpoint line rasterizer
// no dependencies; used by every other rtl file but the defines header
package mlr_pkg;

    localparam int COORD_W   = 6;
    localparam int GRID_SIZE = 64;
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);
    localparam int RGB_W     = 24;
    localparam int D_W       = 11;

    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_COLOR = REG_IDX_W'(0);

    typedef enum logic [0:0] {
        OP_MOVE = 1'b0,
        OP_LINE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_GE0,
        COND_LT0,
        COND_GT0
    } t_cond;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0]    start_x;
        logic [COORD_W-1:0]    start_y;
        logic [COORD_W-1:0]    count;
        logic                  major_y;
        logic                  maj_dec;
        logic                  mnr_dec;
        t_cond                 cond;
        logic signed [D_W-1:0] d_init;
        logic signed [D_W-1:0] add_step;
        logic signed [D_W-1:0] add_keep;
    } t_job;

endpackage

// ----- rtl/mlr_ifs.sv -----
// valid/ready channel interfaces: line commands in, pixels out
// depends on mlr_pkg
interface mlr_cmd_if;
    import mlr_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;

    modport source (output valid, operation, end_x, end_y, input ready);
    modport sink   (input valid, operation, end_x, end_y, output ready);
endinterface

interface mlr_pix_if;
    import mlr_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [RGB_W-1:0]   pixel_rgb;
    logic               last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_rgb, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_rgb, last_pixel, output ready);
endinterface

// ----- rtl/midpoint_line_rasterizer_core.sv -----
// top level of the midpoint line rasterizer: pen state, color register, apb port
// depends on mlr_pkg, mlr_ifs, mlr_setup, mlr_seq
//
// usage:
//   i_cmd carries one command per transaction: operation 0 moves the pen to
//   (end_x, end_y), operation 1 draws a line from the pen to that endpoint and
//   then moves the pen there. coordinates above the grid edge are clamped.
//   o_pix returns one transaction per pixel with x, y, the configured color and
//   last_pixel set on the final pixel of the line. the endpoint that ends the
//   walk along the major axis is not drawn, so a line of span n gives n pixels.
//   the apb port holds pixel_color at byte address 0; write it only while idle.
// timing:
//   a move only updates the pen. a line registers its job from the setup logic
//   at acceptance, then the walk loads one pixel per cycle into the output
//   register from the decision unit loop while o_pix is not stalled.
//   i_cmd.ready is low from acceptance of a line until its last pixel has
//   entered the output register.
// reset and stalls:
//   i_rst_n (synchronous) clears the pen to (0,0), the color to 0 and the
//   output valid flag. a stalled o_pix holds the pixel and pauses the walk.
module midpoint_line_rasterizer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mlr_cmd_if.sink                      i_cmd,
    mlr_pix_if.source                    o_pix,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mlr_pkg::PADDR_W-1:0]  paddr,
    input  logic [mlr_pkg::APB_DW-1:0]   pwdata,
    output logic [mlr_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import mlr_pkg::*;

    logic [RGB_W-1:0]     r_color;
    logic [COORD_W-1:0]   r_pen_x, r_pen_y;
    logic [COORD_W-1:0]   end_x, end_y;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 cmd_acc;
    logic                 start;
    logic                 idle;
    t_job                 job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == REG_PIXEL_COLOR) ? APB_DW'(r_color) : '0;

    assign end_x   = (i_cmd.end_x > COORD_MAX) ? COORD_MAX : i_cmd.end_x;
    assign end_y   = (i_cmd.end_y > COORD_MAX) ? COORD_MAX : i_cmd.end_y;
    assign i_cmd.ready = idle;
    assign cmd_acc = i_cmd.valid && i_cmd.ready;
    assign start   = cmd_acc && (i_cmd.operation == OP_LINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= '0;
            r_pen_x <= '0;
            r_pen_y <= '0;
        end else begin
            if (cfg_wr && (reg_idx == REG_PIXEL_COLOR)) begin
                r_color <= pwdata[RGB_W-1:0];
            end
            if (cmd_acc) begin
                r_pen_x <= end_x;
                r_pen_y <= end_y;
            end
        end
    end

    mlr_setup u_setup (
        .i_pen_x (r_pen_x),
        .i_pen_y (r_pen_y),
        .i_end_x (end_x),
        .i_end_y (end_y),
        .o_job   (job)
    );

    mlr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_job   (job),
        .i_rgb   (r_color),
        .o_idle  (idle),
        .o_pix   (o_pix)
    );

endmodule

// ----- rtl/mlr_setup.sv -----
// line setup: classifies the octant and derives start point, span and
// decision increments; depends on mlr_pkg
module mlr_setup (
    input  logic [mlr_pkg::COORD_W-1:0] i_pen_x,
    input  logic [mlr_pkg::COORD_W-1:0] i_pen_y,
    input  logic [mlr_pkg::COORD_W-1:0] i_end_x,
    input  logic [mlr_pkg::COORD_W-1:0] i_end_y,
    output mlr_pkg::t_job               o_job
);
    import mlr_pkg::*;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W-1:0]      adx;
    logic [COORD_W-1:0]      ady;
    logic                    dx_pos;
    logic                    dy_pos;
    logic                    same_sign;
    logic signed [D_W-1:0]   a;
    logic signed [D_W-1:0]   b;

    assign dx     = $signed({1'b0, i_end_x}) - $signed({1'b0, i_pen_x});
    assign dy     = $signed({1'b0, i_end_y}) - $signed({1'b0, i_pen_y});
    assign adx    = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
    assign ady    = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
    assign dx_pos = !dx[COORD_W] && (dx != '0);
    assign dy_pos = !dy[COORD_W] && (dy != '0);
    assign same_sign = (dx_pos == dy_pos);
    assign a      = $signed(D_W'(adx));
    assign b      = $signed(D_W'(ady));

    always_comb begin
        o_job = '0;
        if (dx == '0) begin
            // vertical, ascending y
            o_job.start_x = i_pen_x;
            o_job.start_y = (i_pen_y > i_end_y) ? i_end_y : i_pen_y;
            o_job.count   = ady;
            o_job.major_y = 1'b1;
            o_job.cond    = COND_NEVER;
        end else if (same_sign && (dy != '0) && (ady > adx)) begin
            // steep positive, ascending y
            o_job.start_x  = (i_pen_y > i_end_y) ? i_end_x : i_pen_x;
            o_job.start_y  = (i_pen_y > i_end_y) ? i_end_y : i_pen_y;
            o_job.count    = ady;
            o_job.major_y  = 1'b1;
            o_job.cond     = COND_GE0;
            o_job.d_init   = (a <<< 1) - b;
            o_job.add_step = (a <<< 1) - (b <<< 1);
            o_job.add_keep = a <<< 1;
        end else if ((dy == '0) || (same_sign && (ady <= adx))) begin
            // shallow positive, ascending x
            o_job.start_x  = (i_pen_x > i_end_x) ? i_end_x : i_pen_x;
            o_job.start_y  = (i_pen_x > i_end_x) ? i_end_y : i_pen_y;
            o_job.count    = adx;
            o_job.cond     = COND_LT0;
            o_job.d_init   = a - (b <<< 1);
            o_job.add_step = (a <<< 1) - (b <<< 1);
            o_job.add_keep = -(b <<< 1);
        end else if (ady <= adx) begin
            // shallow negative, ascending x, y steps down
            o_job.start_x  = (i_pen_x > i_end_x) ? i_end_x : i_pen_x;
            o_job.start_y  = (i_pen_x > i_end_x) ? i_end_y : i_pen_y;
            o_job.count    = adx;
            o_job.mnr_dec  = 1'b1;
            o_job.cond     = COND_GT0;
            o_job.d_init   = (b <<< 1) - a;
            o_job.add_step = (b <<< 1) - (a <<< 1);
            o_job.add_keep = b <<< 1;
        end else begin
            // steep negative, descending y
            o_job.start_x  = (i_pen_y < i_end_y) ? i_end_x : i_pen_x;
            o_job.start_y  = (i_pen_y < i_end_y) ? i_end_y : i_pen_y;
            o_job.count    = ady;
            o_job.major_y  = 1'b1;
            o_job.maj_dec  = 1'b1;
            o_job.cond     = COND_LT0;
            o_job.d_init   = b - (a <<< 1);
            o_job.add_step = (b <<< 1) - (a <<< 1);
            o_job.add_keep = -(a <<< 1);
        end
    end

endmodule

// ----- rtl/mlr_dec_unit.sv -----
// shared decision unit: sign and zero test on the decision value and one add
// depends on mlr_pkg
module mlr_dec_unit (
    input  logic signed [mlr_pkg::D_W-1:0] i_d,
    input  mlr_pkg::t_cond                 i_cond,
    input  logic signed [mlr_pkg::D_W-1:0] i_add_step,
    input  logic signed [mlr_pkg::D_W-1:0] i_add_keep,
    output logic                           o_step,
    output logic signed [mlr_pkg::D_W-1:0] o_d_next
);
    import mlr_pkg::*;

    logic neg;
    logic zero;

    assign neg  = i_d[D_W-1];
    assign zero = (i_d == '0);

    always_comb begin
        unique case (i_cond)
            COND_GE0: o_step = !neg;
            COND_LT0: o_step = neg;
            COND_GT0: o_step = !neg && !zero;
            default:  o_step = 1'b0;
        endcase
    end

    assign o_d_next = i_d + (o_step ? i_add_step : i_add_keep);

endmodule

// ----- rtl/mlr_seq.sv -----
// pixel sequencer: walks the major axis one pixel per cycle unless o_pix stalls,
// using the decision unit for the minor step; depends on mlr_pkg, mlr_ifs, mlr_dec_unit
module mlr_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  mlr_pkg::t_job             i_job,
    input  logic [mlr_pkg::RGB_W-1:0] i_rgb,
    output logic                      o_idle,
    mlr_pix_if.source                 o_pix
);
    import mlr_pkg::*;

    t_state                r_state, n_state;
    logic                  r_ov, n_ov;
    logic [COORD_W-1:0]    r_x, r_y, r_cnt;
    logic                  r_major_y, r_maj_dec, r_mnr_dec;
    t_cond                 r_cond;
    logic signed [D_W-1:0] r_d, r_add_step, r_add_keep;
    logic [COORD_W-1:0]    r_px, r_py;
    logic                  r_last;

    logic                  adv;
    logic                  load;
    logic                  step;
    logic signed [D_W-1:0] d_next;
    logic [COORD_W-1:0]    maj_inc, mnr_inc;

    mlr_dec_unit u_dec (
        .i_d        (r_d),
        .i_cond     (r_cond),
        .i_add_step (r_add_step),
        .i_add_keep (r_add_keep),
        .o_step     (step),
        .o_d_next   (d_next)
    );

    // output slot is free when empty or being drained this cycle
    assign adv     = !r_ov || o_pix.ready;
    assign load    = (r_state == S_RUN) && adv;
    assign maj_inc = r_maj_dec ? '1 : COORD_W'(1);
    assign mnr_inc = step ? (r_mnr_dec ? '1 : COORD_W'(1)) : '0;

    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !o_pix.ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_job.count != '0)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (adv) begin
                    n_ov = 1'b1;
                    if (r_cnt == COORD_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_x        <= i_job.start_x;
            r_y        <= i_job.start_y;
            r_cnt      <= i_job.count;
            r_major_y  <= i_job.major_y;
            r_maj_dec  <= i_job.maj_dec;
            r_mnr_dec  <= i_job.mnr_dec;
            r_cond     <= i_job.cond;
            r_d        <= i_job.d_init;
            r_add_step <= i_job.add_step;
            r_add_keep <= i_job.add_keep;
        end else if (load) begin
            r_px   <= r_x;
            r_py   <= r_y;
            r_last <= (r_cnt == COORD_W'(1));
            r_cnt  <= r_cnt - COORD_W'(1);
            r_d    <= d_next;
            if (r_major_y) begin
                r_y <= r_y + maj_inc;
                r_x <= r_x + mnr_inc;
            end else begin
                r_x <= r_x + maj_inc;
                r_y <= r_y + mnr_inc;
            end
        end
    end

    assign o_idle           = (r_state == S_IDLE);
    assign o_pix.valid      = r_ov;
    assign o_pix.pixel_x    = r_px;
    assign o_pix.pixel_y    = r_py;
    assign o_pix.pixel_rgb  = i_rgb;
    assign o_pix.last_pixel = r_last;

endmodule

// ----- rtl/mlr_checker.sv -----
// port-level checks for midpoint_line_rasterizer_core, attached by bind
// depends on mlr_pkg and the defines header
`include "midpoint_line_rasterizer_core_defines.svh"

module mlr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cmd_valid,
    input logic                         i_cmd_ready,
    input logic                         i_cmd_op,
    input logic                         i_pix_valid,
    input logic                         i_pix_ready,
    input logic [mlr_pkg::COORD_W-1:0]  i_pix_x,
    input logic [mlr_pkg::COORD_W-1:0]  i_pix_y,
    input logic                         i_pix_last
);
    import mlr_pkg::*;

    // a pending pixel that is not the last means the line is still running
    `MLR_ASSERT_SAME(a_busy_mid_line, i_clk, i_rst_n, i_pix_valid && !i_pix_last, !i_cmd_ready)

    // a move transaction never produces a pixel
    `MLR_ASSERT_NEXT(a_move_silent, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready && (i_cmd_op == OP_MOVE) && !i_pix_valid, !i_pix_valid)

    // pixels of one line come back to back while the receiver keeps up
    `MLR_ASSERT_NEXT(a_line_no_gap, i_clk, i_rst_n, i_pix_valid && i_pix_ready && !i_pix_last, i_pix_valid)

    // a stalled pixel holds
    `MLR_ASSERT_NEXT(a_pix_hold, i_clk, i_rst_n, i_pix_valid && !i_pix_ready, i_pix_valid && $stable(i_pix_x) && $stable(i_pix_y) && $stable(i_pix_last))

endmodule

bind midpoint_line_rasterizer_core mlr_checker u_mlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_cmd_op    (i_cmd.operation),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pix_x     (o_pix.pixel_x),
    .i_pix_y     (o_pix.pixel_y),
    .i_pix_last  (o_pix.last_pixel)
);
